@@ design/jeoc_pkg.sv @@
// Package for the job event order checker: widths, codes and shared types.
// No dependencies; imported by the interfaces and every module.
package jeoc_pkg;

  localparam int unsigned SIZE_BITS_DEF = 24;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned FUNC_W        = 3;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned PROG_W        = 11;
  localparam int unsigned STATUS_W      = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACCEPTED   = 3'd0,
    FUNC_PROGRESS   = 3'd1,
    FUNC_COMPLETED  = 3'd2,
    FUNC_FAILED     = 3'd3,
    FUNC_CANCEL_ACK = 3'd4,
    FUNC_RELEASED   = 3'd5
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TRANSCRIPT = 2'd0,
    KIND_AUDIO      = 2'd1,
    KIND_VAD        = 2'd2,
    KIND_OTHER      = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK                = 4'd0,
    ST_ID_MISMATCH       = 4'd1,
    ST_AFTER_RELEASE     = 4'd2,
    ST_AFTER_TERMINAL    = 4'd3,
    ST_ACCEPT_ORDER      = 4'd4,
    ST_NOT_ACCEPTED      = 4'd5,
    ST_PROG_AFTER_CANCEL = 4'd6,
    ST_KIND_MISMATCH     = 4'd7,
    ST_PROG_GAP          = 4'd8,
    ST_PROG_LIMIT        = 4'd9,
    ST_TOTAL_OVER        = 4'd10,
    ST_VAD_MISMATCH      = 4'd11,
    ST_CANCEL_NO_REQ     = 4'd12,
    ST_CANCEL_DUP        = 4'd13,
    ST_RELEASE_EARLY     = 4'd14
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JOB_ID         = 3'd0,
    CFG_RESULT_KIND    = 3'd1,
    CFG_PROGRESS_LIMIT = 3'd2,
    CFG_FRAME_COUNT    = 3'd3,
    CFG_MAX_TEXT       = 3'd4,
    CFG_MAX_TOKENS     = 3'd5,
    CFG_MAX_PCM        = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic seen_any;
    logic was_accepted;
    logic is_terminal;
    logic cancel_acked;
    logic is_released;
  } flags_t;

endpackage

@@ design/jeoc_if.sv @@
// Handshake channels of the job event order checker: event beats in, result beats out.
// Depends on jeoc_pkg.
interface jeoc_evt_if import jeoc_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ID_W-1:0]      event_id;
  logic [PROG_W-1:0]    progress_number;
  logic                 has_result;
  logic [KIND_W-1:0]    payload_kind;
  logic [SIZE_BITS-1:0] text_len;
  logic [SIZE_BITS-1:0] word_bytes;
  logic [SIZE_BITS-1:0] token_count;
  logic [SIZE_BITS-1:0] pcm_len;
  logic [SIZE_BITS-1:0] prob_count;
  logic                 cancel_requested;

  modport source (
    output valid, func, event_id, progress_number, has_result, payload_kind,
           text_len, word_bytes, token_count, pcm_len, prob_count, cancel_requested,
    input  ready
  );
  modport sink (
    input  valid, func, event_id, progress_number, has_result, payload_kind,
           text_len, word_bytes, token_count, pcm_len, prob_count, cancel_requested,
    output ready
  );
endinterface

interface jeoc_res_if import jeoc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PROG_W-1:0]   progress_seen;

  modport source (output valid, status, progress_seen, input ready);
  modport sink (input valid, status, progress_seen, output ready);
endinterface

@@ design/jeoc_eval.sv @@
// Evaluation of one registered event against the job state: status and next state.
// Depends on jeoc_pkg.
module jeoc_eval import jeoc_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic [ID_W-1:0]      job_id_i,
  input  logic [KIND_W-1:0]    job_kind_i,
  input  logic [PROG_W-1:0]    prog_limit_i,
  input  logic [SIZE_BITS-1:0] frame_count_i,
  input  logic [SIZE_BITS-1:0] max_text_i,
  input  logic [SIZE_BITS-1:0] max_tokens_i,
  input  logic [SIZE_BITS-1:0] max_pcm_i,
  input  flags_t               flags_i,
  input  logic [PROG_W-1:0]    prog_i,
  input  logic [SIZE_BITS-1:0] text_tot_i,
  input  logic [SIZE_BITS-1:0] word_tot_i,
  input  logic [SIZE_BITS-1:0] token_tot_i,
  input  logic [SIZE_BITS-1:0] pcm_tot_i,
  input  logic [SIZE_BITS-1:0] prob_tot_i,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [ID_W-1:0]      event_id_i,
  input  logic [PROG_W-1:0]    prog_num_i,
  input  logic                 has_result_i,
  input  logic [KIND_W-1:0]    pkind_i,
  input  logic [SIZE_BITS-1:0] text_i,
  input  logic [SIZE_BITS-1:0] word_i,
  input  logic [SIZE_BITS-1:0] token_i,
  input  logic [SIZE_BITS-1:0] pcm_i,
  input  logic [SIZE_BITS-1:0] prob_i,
  input  logic                 cancel_req_i,
  output status_e              status_o,
  output flags_t               flags_o,
  output logic [PROG_W-1:0]    prog_o,
  output logic [SIZE_BITS-1:0] text_tot_o,
  output logic [SIZE_BITS-1:0] word_tot_o,
  output logic [SIZE_BITS-1:0] token_tot_o,
  output logic [SIZE_BITS-1:0] pcm_tot_o,
  output logic [SIZE_BITS-1:0] prob_tot_o
);

  logic [PROG_W:0]    prog_next;
  logic [SIZE_BITS:0] text_sum, word_sum, token_sum, pcm_sum, prob_sum;
  logic               is_trans, is_audio, is_vad;
  logic               is_prog;
  logic               over_tot, vad_bad;
  status_e            res_st;
  status_e            st;
  flags_t             fl;

  assign prog_next = {1'b0, prog_i} + {{PROG_W{1'b0}}, 1'b1};
  assign is_trans  = (kind_e'(pkind_i) == KIND_TRANSCRIPT);
  assign is_audio  = (kind_e'(pkind_i) == KIND_AUDIO);
  assign is_vad    = (kind_e'(pkind_i) == KIND_VAD);
  assign is_prog   = (func_e'(func_i) == FUNC_PROGRESS);

  assign text_sum  = {1'b0, text_tot_i}  + (is_trans ? {1'b0, text_i}  : '0);
  assign word_sum  = {1'b0, word_tot_i}  + (is_trans ? {1'b0, word_i}  : '0);
  assign token_sum = {1'b0, token_tot_i} + (is_trans ? {1'b0, token_i} : '0);
  assign pcm_sum   = {1'b0, pcm_tot_i}   + (is_audio ? {1'b0, pcm_i}   : '0);
  assign prob_sum  = {1'b0, prob_tot_i}  + (is_vad   ? {1'b0, prob_i}  : '0);

  assign over_tot = (text_sum > {1'b0, max_text_i}) || (word_sum > {1'b0, max_text_i}) ||
                    (token_sum > {1'b0, max_tokens_i}) || (pcm_sum > {1'b0, max_pcm_i});
  assign vad_bad  = (kind_e'(job_kind_i) == KIND_VAD) &&
                    ((prob_sum > {1'b0, frame_count_i}) ||
                     (!is_prog && (prob_sum != {1'b0, frame_count_i})));

  always_comb begin
    if (!flags_i.was_accepted) begin
      res_st = ST_NOT_ACCEPTED;
    end else if (is_prog && flags_i.cancel_acked) begin
      res_st = ST_PROG_AFTER_CANCEL;
    end else if (!has_result_i || (pkind_i != job_kind_i)) begin
      res_st = ST_KIND_MISMATCH;
    end else if (is_prog && ({1'b0, prog_num_i} != prog_next)) begin
      res_st = ST_PROG_GAP;
    end else if (is_prog && (prog_next > {1'b0, prog_limit_i})) begin
      res_st = ST_PROG_LIMIT;
    end else if (over_tot) begin
      res_st = ST_TOTAL_OVER;
    end else if (vad_bad) begin
      res_st = ST_VAD_MISMATCH;
    end else begin
      res_st = ST_OK;
    end
  end

  always_comb begin
    st = ST_OK;
    if (event_id_i != job_id_i) begin
      st = ST_ID_MISMATCH;
    end else if (flags_i.is_released) begin
      st = ST_AFTER_RELEASE;
    end else if (flags_i.is_terminal && (func_e'(func_i) != FUNC_RELEASED)) begin
      st = ST_AFTER_TERMINAL;
    end else begin
      case (func_e'(func_i))
        FUNC_ACCEPTED: begin
          if (flags_i.seen_any) st = ST_ACCEPT_ORDER;
        end
        FUNC_PROGRESS, FUNC_COMPLETED: begin
          st = res_st;
        end
        FUNC_FAILED: begin
          st = ST_OK;
        end
        FUNC_CANCEL_ACK: begin
          if (!cancel_req_i) st = ST_CANCEL_NO_REQ;
          else if (flags_i.cancel_acked) st = ST_CANCEL_DUP;
        end
        FUNC_RELEASED: begin
          if (!flags_i.is_terminal) st = ST_RELEASE_EARLY;
        end
        default: begin
          st = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    fl          = flags_i;
    prog_o      = prog_i;
    text_tot_o  = text_tot_i;
    word_tot_o  = word_tot_i;
    token_tot_o = token_tot_i;
    pcm_tot_o   = pcm_tot_i;
    prob_tot_o  = prob_tot_i;
    if (st == ST_OK) begin
      case (func_e'(func_i))
        FUNC_ACCEPTED: begin
          fl.seen_any     = 1'b1;
          fl.was_accepted = 1'b1;
        end
        FUNC_PROGRESS, FUNC_COMPLETED: begin
          fl.seen_any = 1'b1;
          if (is_prog) prog_o = prog_next[PROG_W-1:0];
          else fl.is_terminal = 1'b1;
          text_tot_o  = text_sum[SIZE_BITS-1:0];
          word_tot_o  = word_sum[SIZE_BITS-1:0];
          token_tot_o = token_sum[SIZE_BITS-1:0];
          pcm_tot_o   = pcm_sum[SIZE_BITS-1:0];
          prob_tot_o  = prob_sum[SIZE_BITS-1:0];
        end
        FUNC_FAILED: begin
          fl.seen_any    = 1'b1;
          fl.is_terminal = 1'b1;
        end
        FUNC_CANCEL_ACK: begin
          fl.seen_any     = 1'b1;
          fl.cancel_acked = 1'b1;
        end
        FUNC_RELEASED: begin
          fl.seen_any    = 1'b1;
          fl.is_released = 1'b1;
        end
        default: begin
          fl = flags_i;
        end
      endcase
    end
  end

  assign status_o = st;
  assign flags_o  = fl;

endmodule

@@ design/job_event_order_checker_top.sv @@
// Top level of the job event order checker: config registers, event and result registers.
// Depends on jeoc_pkg, jeoc_if and jeoc_eval.
// An event moves from the event register into the result register, which drives res_o.
// Throughput: one event per cycle; while a result waits, one more event is held, then stall.
// State is updated as an event moves from the event register into the result register.
// Reset clears all config registers, lifecycle flags, progress count and totals.
module job_event_order_checker_top import jeoc_pkg::*; #(
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  jeoc_evt_if.sink              evt_i,
  jeoc_res_if.source            res_o
);

  logic [ID_W-1:0]      job_id_q;
  logic [KIND_W-1:0]    job_kind_q;
  logic [PROG_W-1:0]    prog_limit_q;
  logic [SIZE_BITS-1:0] frame_count_q, max_text_q, max_tokens_q, max_pcm_q;

  flags_t               flags_q, flags_d;
  logic [PROG_W-1:0]    prog_q, prog_d;
  logic [SIZE_BITS-1:0] text_tot_q, word_tot_q, token_tot_q, pcm_tot_q, prob_tot_q;
  logic [SIZE_BITS-1:0] text_tot_d, word_tot_d, token_tot_d, pcm_tot_d, prob_tot_d;

  logic                 evt_vld_q;
  logic [FUNC_W-1:0]    evt_func_q;
  logic [ID_W-1:0]      evt_id_q;
  logic [PROG_W-1:0]    evt_pnum_q;
  logic                 evt_has_q;
  logic [KIND_W-1:0]    evt_kind_q;
  logic [SIZE_BITS-1:0] evt_text_q, evt_word_q, evt_token_q, evt_pcm_q, evt_prob_q;
  logic                 evt_cancel_q;

  logic                 res_vld_q;
  status_e              res_st_q, st_d;
  logic [PROG_W-1:0]    res_prog_q;

  logic                 advance;
  logic                 evt_take;

  assign advance  = evt_vld_q && (!res_vld_q || res_o.ready);
  assign evt_i.ready = !evt_vld_q || advance;
  assign evt_take = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_id_q      <= '0;
      job_kind_q    <= '0;
      prog_limit_q  <= '0;
      frame_count_q <= '0;
      max_text_q    <= '0;
      max_tokens_q  <= '0;
      max_pcm_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_JOB_ID:         job_id_q      <= cfg_data_i[ID_W-1:0];
        CFG_RESULT_KIND:    job_kind_q    <= cfg_data_i[KIND_W-1:0];
        CFG_PROGRESS_LIMIT: prog_limit_q  <= cfg_data_i[PROG_W-1:0];
        CFG_FRAME_COUNT:    frame_count_q <= cfg_data_i[SIZE_BITS-1:0];
        CFG_MAX_TEXT:       max_text_q    <= cfg_data_i[SIZE_BITS-1:0];
        CFG_MAX_TOKENS:     max_tokens_q  <= cfg_data_i[SIZE_BITS-1:0];
        CFG_MAX_PCM:        max_pcm_q     <= cfg_data_i[SIZE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_take) begin
      evt_func_q   <= evt_i.func;
      evt_id_q     <= evt_i.event_id;
      evt_pnum_q   <= evt_i.progress_number;
      evt_has_q    <= evt_i.has_result;
      evt_kind_q   <= evt_i.payload_kind;
      evt_text_q   <= evt_i.text_len;
      evt_word_q   <= evt_i.word_bytes;
      evt_token_q  <= evt_i.token_count;
      evt_pcm_q    <= evt_i.pcm_len;
      evt_prob_q   <= evt_i.prob_count;
      evt_cancel_q <= evt_i.cancel_requested;
    end
  end

  jeoc_eval #(
    .SIZE_BITS(SIZE_BITS)
  ) u_eval (
    .job_id_i      (job_id_q),
    .job_kind_i    (job_kind_q),
    .prog_limit_i  (prog_limit_q),
    .frame_count_i (frame_count_q),
    .max_text_i    (max_text_q),
    .max_tokens_i  (max_tokens_q),
    .max_pcm_i     (max_pcm_q),
    .flags_i       (flags_q),
    .prog_i        (prog_q),
    .text_tot_i    (text_tot_q),
    .word_tot_i    (word_tot_q),
    .token_tot_i   (token_tot_q),
    .pcm_tot_i     (pcm_tot_q),
    .prob_tot_i    (prob_tot_q),
    .func_i        (evt_func_q),
    .event_id_i    (evt_id_q),
    .prog_num_i    (evt_pnum_q),
    .has_result_i  (evt_has_q),
    .pkind_i       (evt_kind_q),
    .text_i        (evt_text_q),
    .word_i        (evt_word_q),
    .token_i       (evt_token_q),
    .pcm_i         (evt_pcm_q),
    .prob_i        (evt_prob_q),
    .cancel_req_i  (evt_cancel_q),
    .status_o      (st_d),
    .flags_o       (flags_d),
    .prog_o        (prog_d),
    .text_tot_o    (text_tot_d),
    .word_tot_o    (word_tot_d),
    .token_tot_o   (token_tot_d),
    .pcm_tot_o     (pcm_tot_d),
    .prob_tot_o    (prob_tot_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      prog_q      <= '0;
      text_tot_q  <= '0;
      word_tot_q  <= '0;
      token_tot_q <= '0;
      pcm_tot_q   <= '0;
      prob_tot_q  <= '0;
    end else if (advance) begin
      flags_q     <= flags_d;
      prog_q      <= prog_d;
      text_tot_q  <= text_tot_d;
      word_tot_q  <= word_tot_d;
      token_tot_q <= token_tot_d;
      pcm_tot_q   <= pcm_tot_d;
      prob_tot_q  <= prob_tot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_st_q   <= st_d;
      res_prog_q <= prog_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.status        = res_st_q;
  assign res_o.progress_seen = res_prog_q;

  a_prog_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (st_d == ST_OK) && (func_e'(evt_func_q) == FUNC_PROGRESS)
    |=> prog_q == $past(prog_q) + 1'b1)
    else $error("progress count did not advance on accepted progress event");

  a_refuse_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (st_d != ST_OK) |=> (flags_q == $past(flags_q)) && $stable(prog_q) &&
    $stable(text_tot_q) && $stable(prob_tot_q))
    else $error("state changed on a refused event");

  a_release_terminal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.is_released |-> flags_q.is_terminal)
    else $error("released without terminal");

  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_vld_q && !advance |=> evt_vld_q && $stable(evt_id_q))
    else $error("event register lost a pending beat");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for job_event_order_checker_top: drives event beats with random gaps and
// checks every verdict beat against an in-bench lifecycle model of one job.
// Depends on jeoc_pkg, jeoc_if and the design top level.

import jeoc_pkg::*;

typedef struct packed {
  logic [FUNC_W-1:0]        func;
  logic [ID_W-1:0]          event_id;
  logic [PROG_W-1:0]        progress_number;
  logic                     has_result;
  kind_e                    payload_kind;
  logic [SIZE_BITS_DEF-1:0] text_len;
  logic [SIZE_BITS_DEF-1:0] word_bytes;
  logic [SIZE_BITS_DEF-1:0] token_count;
  logic [SIZE_BITS_DEF-1:0] pcm_len;
  logic [SIZE_BITS_DEF-1:0] prob_count;
  logic                     cancel_requested;
} job_event_t;

// one bit wider than the registers so sums never wrap
typedef struct packed {
  logic [SIZE_BITS_DEF:0] text;
  logic [SIZE_BITS_DEF:0] word;
  logic [SIZE_BITS_DEF:0] token;
  logic [SIZE_BITS_DEF:0] pcm;
  logic [SIZE_BITS_DEF:0] prob;
} totals_t;

typedef struct packed {
  status_e           status;
  logic [PROG_W-1:0] seen;
} verdict_t;

class job_lifecycle;
  logic [ID_W-1:0]          job_id;
  kind_e                    result_kind;
  logic [PROG_W-1:0]        prog_limit;
  logic [SIZE_BITS_DEF-1:0] frames;
  logic [SIZE_BITS_DEF-1:0] text_cap;
  logic [SIZE_BITS_DEF-1:0] token_cap;
  logic [SIZE_BITS_DEF-1:0] pcm_cap;
  flags_t                   flags;
  logic [PROG_W-1:0]        prog_count;
  totals_t                  sums;
  verdict_t                 verdicts_due[$];
  int                       faults;

  function new();
    job_id = '0;
    result_kind = KIND_TRANSCRIPT;
    prog_limit = '0;
    frames = '0;
    text_cap = '0;
    token_cap = '0;
    pcm_cap = '0;
    flags = '0;
    prog_count = '0;
    sums = '0;
    faults = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_JOB_ID:         job_id = v[ID_W-1:0];
      CFG_RESULT_KIND:    result_kind = kind_e'(v[KIND_W-1:0]);
      CFG_PROGRESS_LIMIT: prog_limit = v[PROG_W-1:0];
      CFG_FRAME_COUNT:    frames = v[SIZE_BITS_DEF-1:0];
      CFG_MAX_TEXT:       text_cap = v[SIZE_BITS_DEF-1:0];
      CFG_MAX_TOKENS:     token_cap = v[SIZE_BITS_DEF-1:0];
      CFG_MAX_PCM:        pcm_cap = v[SIZE_BITS_DEF-1:0];
      default: ;
    endcase
  endfunction

  function status_e judge(job_event_t ev, inout totals_t t);
    logic [PROG_W:0] nxt;
    logic            progress;
    nxt = {1'b0, prog_count} + 1'b1;
    progress = (ev.func == FUNC_PROGRESS);
    if (ev.event_id != job_id) return ST_ID_MISMATCH;
    if (flags.is_released) return ST_AFTER_RELEASE;
    if (flags.is_terminal && ev.func != FUNC_RELEASED) return ST_AFTER_TERMINAL;
    case (ev.func)
      FUNC_ACCEPTED: return flags.seen_any ? ST_ACCEPT_ORDER : ST_OK;
      FUNC_PROGRESS, FUNC_COMPLETED: begin
        if (!flags.was_accepted) return ST_NOT_ACCEPTED;
        if (progress && flags.cancel_acked) return ST_PROG_AFTER_CANCEL;
        if (!ev.has_result || ev.payload_kind != result_kind) return ST_KIND_MISMATCH;
        if (progress) begin
          if ({1'b0, ev.progress_number} != nxt) return ST_PROG_GAP;
          if (nxt > {1'b0, prog_limit}) return ST_PROG_LIMIT;
        end
        case (ev.payload_kind)
          KIND_TRANSCRIPT: begin
            t.text = t.text + ev.text_len;
            t.word = t.word + ev.word_bytes;
            t.token = t.token + ev.token_count;
          end
          KIND_AUDIO: t.pcm = t.pcm + ev.pcm_len;
          KIND_VAD:   t.prob = t.prob + ev.prob_count;
          default: ;
        endcase
        if (t.text > text_cap || t.word > text_cap || t.token > token_cap ||
            t.pcm > pcm_cap) return ST_TOTAL_OVER;
        if (result_kind == KIND_VAD && (t.prob > frames || (!progress && t.prob != frames)))
          return ST_VAD_MISMATCH;
        return ST_OK;
      end
      FUNC_CANCEL_ACK: begin
        if (!ev.cancel_requested) return ST_CANCEL_NO_REQ;
        if (flags.cancel_acked) return ST_CANCEL_DUP;
        return ST_OK;
      end
      FUNC_RELEASED: return flags.is_terminal ? ST_OK : ST_RELEASE_EARLY;
      default: return ST_OK;
    endcase
  endfunction

  function void take_event(job_event_t ev);
    totals_t  t;
    status_e  st;
    verdict_t v;
    t = sums;
    st = judge(ev, t);
    if (st == ST_OK && ev.func <= FUNC_RELEASED) begin
      flags.seen_any = 1'b1;
      case (ev.func)
        FUNC_ACCEPTED:               flags.was_accepted = 1'b1;
        FUNC_PROGRESS:               prog_count = prog_count + 1'b1;
        FUNC_COMPLETED, FUNC_FAILED: flags.is_terminal = 1'b1;
        FUNC_CANCEL_ACK:             flags.cancel_acked = 1'b1;
        default:                     flags.is_released = 1'b1;
      endcase
      sums = t;
    end
    v.status = st;
    v.seen = prog_count;
    verdicts_due.push_back(v);
  endfunction

  function void check_verdict(logic [STATUS_W-1:0] status, logic [PROG_W-1:0] seen);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("verdict beat with nothing due: status %0d progress_seen %0d", status, seen);
      return;
    end
    want = verdicts_due.pop_front();
    if (status !== want.status || seen !== want.seen) begin
      faults++;
      if (faults <= 10)
        $display("verdict mismatch: status exp %0d got %0d, progress_seen exp %0d got %0d",
                 want.status, status, want.seen, seen);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam logic [SIZE_BITS_DEF-1:0] SIZE_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    no_idle;
  job_lifecycle          tracker;

  jeoc_evt_if evt_bus ();
  jeoc_res_if res_bus ();

  job_event_order_checker_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evt_i      (evt_bus),
    .res_o      (res_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    tracker.set_reg(idx, v);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_event(job_event_t ev);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      evt_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.func <= ev.func;
    evt_bus.event_id <= ev.event_id;
    evt_bus.progress_number <= ev.progress_number;
    evt_bus.has_result <= ev.has_result;
    evt_bus.payload_kind <= ev.payload_kind;
    evt_bus.text_len <= ev.text_len;
    evt_bus.word_bytes <= ev.word_bytes;
    evt_bus.token_count <= ev.token_count;
    evt_bus.pcm_len <= ev.pcm_len;
    evt_bus.prob_count <= ev.prob_count;
    evt_bus.cancel_requested <= ev.cancel_requested;
    @(posedge clk);
    while (!evt_bus.ready) @(posedge clk);
    tracker.take_event(ev);
  endtask

  // hold off the sender until every verdict is back
  task automatic drain();
    @(negedge clk);
    evt_bus.valid <= 1'b0;
    while (tracker.verdicts_due.size() != 0) @(posedge clk);
  endtask

  function automatic job_event_t quiet_event(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id);
    job_event_t ev;
    ev = '0;
    ev.func = func;
    ev.event_id = id;
    ev.payload_kind = KIND_TRANSCRIPT;
    return ev;
  endfunction

  function automatic job_event_t noise_event();
    job_event_t ev;
    ev.func = $urandom_range(0, 7);
    ev.event_id = ($urandom_range(0, 3) == 0) ? tracker.job_id : $urandom;
    ev.progress_number = $urandom_range(0, 2047);
    ev.has_result = $urandom_range(0, 1);
    ev.payload_kind = kind_e'($urandom_range(0, 3));
    ev.text_len = $urandom_range(0, SIZE_MAX);
    ev.word_bytes = $urandom_range(0, SIZE_MAX);
    ev.token_count = $urandom_range(0, SIZE_MAX);
    ev.pcm_len = $urandom_range(0, SIZE_MAX);
    ev.prob_count = $urandom_range(0, SIZE_MAX);
    ev.cancel_requested = $urandom_range(0, 1);
    return ev;
  endfunction

  // size that mostly stays under the ceiling, sometimes lands on or just past it
  function automatic logic [SIZE_BITS_DEF-1:0] fit(logic [SIZE_BITS_DEF:0] total,
                                                   logic [SIZE_BITS_DEF-1:0] cap);
    logic [SIZE_BITS_DEF:0] room;
    int                     r;
    room = (cap >= total) ? cap - total : '0;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, (room > 4000) ? 4000 : room);
    if (r < 17) return room[SIZE_BITS_DEF-1:0];
    if (r < 19) return room[SIZE_BITS_DEF-1:0] + 1'b1;
    return $urandom_range(0, SIZE_MAX);
  endfunction

  function automatic job_event_t shaped_event();
    job_event_t ev;
    int         r;
    ev = noise_event();
    ev.event_id = tracker.job_id;
    r = $urandom_range(0, 99);
    if (r < 55) ev.func = FUNC_PROGRESS;
    else if (r < 67) ev.func = FUNC_COMPLETED;
    else if (r < 75) ev.func = FUNC_CANCEL_ACK;
    else if (r < 80) ev.func = FUNC_ACCEPTED;
    else if (r < 86) ev.func = FUNC_RELEASED;
    else if (r < 95) ev.func = FUNC_FAILED;
    else ev.func = $urandom_range(6, 7);
    if ($urandom_range(0, 9) != 0) ev.progress_number = tracker.prog_count + 1'b1;
    ev.has_result = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 9) != 0) ev.payload_kind = tracker.result_kind;
    case (ev.payload_kind)
      KIND_TRANSCRIPT: begin
        ev.text_len = fit(tracker.sums.text, tracker.text_cap);
        ev.word_bytes = fit(tracker.sums.word, tracker.text_cap);
        ev.token_count = fit(tracker.sums.token, tracker.token_cap);
      end
      KIND_AUDIO: ev.pcm_len = fit(tracker.sums.pcm, tracker.pcm_cap);
      KIND_VAD:   ev.prob_count = fit(tracker.sums.prob, tracker.frames);
      default: ;
    endcase
    return ev;
  endfunction

  // keep the job open and cancel unacknowledged until the closing sequence
  function automatic void hold_open(inout job_event_t ev);
    totals_t t;
    status_e st;
    t = tracker.sums;
    st = tracker.judge(ev, t);
    if (st == ST_OK) begin
      if (ev.func == FUNC_COMPLETED) ev.has_result = 1'b0;
      if (ev.func == FUNC_FAILED) ev.event_id = ~tracker.job_id;
      if (ev.func == FUNC_CANCEL_ACK) ev.cancel_requested = 1'b0;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_cap(logic [SIZE_BITS_DEF:0] total);
    logic [CFG_DATA_W:0] sum;
    int                  r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r < 3) return SIZE_MAX;
    sum = total + $urandom_range(0, 4000);
    return (sum > SIZE_MAX) ? SIZE_MAX : sum[CFG_DATA_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    int r;
    int lim;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return 1500;
    lim = tracker.prog_count + $urandom_range(0, 60);
    return (lim > 1500) ? 1500 : lim;
  endfunction

  task automatic configure_job();
    logic [CFG_DATA_W-1:0] id;
    logic [SIZE_BITS_DEF:0] text_hi;
    case ($urandom_range(0, 3))
      0: id = '0;
      1: id = '1;
      default: id = $urandom;
    endcase
    text_hi = (tracker.sums.text > tracker.sums.word) ? tracker.sums.text : tracker.sums.word;
    write_reg(CFG_JOB_ID, id);
    write_reg(CFG_RESULT_KIND, $urandom_range(0, 3));
    write_reg(CFG_PROGRESS_LIMIT, pick_limit());
    write_reg(CFG_FRAME_COUNT, pick_cap(tracker.sums.prob));
    write_reg(CFG_MAX_TEXT, pick_cap(text_hi));
    write_reg(CFG_MAX_TOKENS, pick_cap(tracker.sums.token));
    write_reg(CFG_MAX_PCM, pick_cap(tracker.sums.pcm));
    end_writes();
  endtask

  initial begin
    int stall;
    res_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 10);
      @(negedge clk);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
      while (!res_bus.valid) @(posedge clk);
      tracker.check_verdict(res_bus.status, res_bus.progress_seen);
    end
  end

  initial begin
    job_event_t        ev;
    int                phase;
    int                n;
    logic [PROG_W-1:0] lim;
    tracker = new();
    no_idle = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_JOB_ID;
    cfg_data = '0;
    evt_bus.valid = 1'b0;
    evt_bus.func = FUNC_ACCEPTED;
    evt_bus.event_id = '0;
    evt_bus.progress_number = '0;
    evt_bus.has_result = 1'b0;
    evt_bus.payload_kind = KIND_TRANSCRIPT;
    evt_bus.text_len = '0;
    evt_bus.word_bytes = '0;
    evt_bus.token_count = '0;
    evt_bus.pcm_len = '0;
    evt_bus.prob_count = '0;
    evt_bus.cancel_requested = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // lifecycle order before the job is accepted
    send_event(quiet_event(FUNC_ACCEPTED, '1));
    ev = quiet_event(FUNC_PROGRESS, '0);
    ev.has_result = 1'b1;
    ev.progress_number = 1;
    send_event(ev);
    ev.func = FUNC_COMPLETED;
    send_event(ev);
    send_event(quiet_event(FUNC_RELEASED, '0));
    send_event(quiet_event(FUNC_CANCEL_ACK, '0));
    send_event(quiet_event(3'd6, '0));
    send_event(quiet_event(3'd7, '0));
    send_event(quiet_event(FUNC_ACCEPTED, '0));
    send_event(quiet_event(FUNC_ACCEPTED, '0));

    // result checks on a transcript job
    drain();
    write_reg(CFG_JOB_ID, '1);
    write_reg(CFG_RESULT_KIND, KIND_TRANSCRIPT);
    write_reg(CFG_PROGRESS_LIMIT, 2);
    write_reg(CFG_FRAME_COUNT, '0);
    write_reg(CFG_MAX_TEXT, SIZE_MAX);
    write_reg(CFG_MAX_TOKENS, SIZE_MAX);
    write_reg(CFG_MAX_PCM, '0);
    end_writes();
    ev = quiet_event(FUNC_PROGRESS, '1);
    ev.progress_number = 1;
    send_event(ev);
    ev.has_result = 1'b1;
    ev.payload_kind = KIND_AUDIO;
    send_event(ev);
    ev.payload_kind = KIND_TRANSCRIPT;
    ev.progress_number = 2;
    send_event(ev);
    ev.progress_number = 1;
    ev.text_len = 1;
    ev.word_bytes = 2;
    ev.token_count = 5;
    ev.pcm_len = SIZE_MAX;
    send_event(ev);
    ev.progress_number = 2;
    ev.text_len = SIZE_MAX;
    send_event(ev);
    ev.text_len = '0;
    send_event(ev);
    ev.progress_number = 3;
    send_event(ev);

    // vad frame accounting
    drain();
    write_reg(CFG_RESULT_KIND, KIND_VAD);
    write_reg(CFG_PROGRESS_LIMIT, 1500);
    write_reg(CFG_FRAME_COUNT, 10);
    end_writes();
    ev = quiet_event(FUNC_PROGRESS, '1);
    ev.has_result = 1'b1;
    ev.payload_kind = KIND_VAD;
    ev.progress_number = 3;
    ev.prob_count = 11;
    send_event(ev);
    ev.prob_count = 4;
    send_event(ev);
    ev.func = FUNC_COMPLETED;
    send_event(ev);
    ev.func = FUNC_CANCEL_ACK;
    send_event(ev);

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      configure_job();
      no_idle = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        ev = ($urandom_range(0, 4) != 0) ? shaped_event() : noise_event();
        hold_open(ev);
        send_event(ev);
      end
    end
    no_idle = 1'b0;

    // cancel, close and release the job
    drain();
    lim = (tracker.prog_count < 1500) ? tracker.prog_count + 1'b1 : tracker.prog_count;
    write_reg(CFG_RESULT_KIND, KIND_VAD);
    write_reg(CFG_FRAME_COUNT, tracker.sums.prob + 5);
    write_reg(CFG_PROGRESS_LIMIT, lim);
    end_writes();
    ev = quiet_event(FUNC_PROGRESS, tracker.job_id);
    ev.has_result = 1'b1;
    ev.payload_kind = KIND_VAD;
    ev.progress_number = tracker.prog_count + 1'b1;
    ev.prob_count = 2;
    send_event(ev);
    ev.func = FUNC_CANCEL_ACK;
    ev.cancel_requested = 1'b1;
    send_event(ev);
    send_event(ev);
    ev.func = FUNC_PROGRESS;
    send_event(ev);
    ev.func = FUNC_COMPLETED;
    ev.prob_count = $urandom_range(0, 1) ? 3 : 1;
    send_event(ev);
    send_event(quiet_event(FUNC_FAILED, tracker.job_id));
    send_event(quiet_event(FUNC_PROGRESS, tracker.job_id));
    send_event(quiet_event(FUNC_RELEASED, tracker.job_id));
    send_event(quiet_event(FUNC_RELEASED, tracker.job_id));
    send_event(quiet_event(FUNC_ACCEPTED, ~tracker.job_id));
    for (n = 0; n < 20; n++) send_event(noise_event());

    drain();
    repeat (10) @(posedge clk);
    if (tracker.faults == 0 && tracker.verdicts_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
